@@ rtl/framed_packet_receiver_heartbeat_core_assert.svh @@
// Assertion macros for the framed packet receiver with heartbeat watchdog.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef FRAMED_PACKET_RECEIVER_HEARTBEAT_CORE_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_HEARTBEAT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FPRHB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FPRHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fprhb_pkg.sv @@
// Shared types and constants for the framed packet receiver with heartbeat watchdog.
// No dependencies; used by fprhb_engine, framed_packet_receiver_heartbeat_core and the dv files.
package fprhb_pkg;

  // Frame geometry
  localparam int FRAME_BYTES      = 12;
  localparam int FILL_W           = $clog2(FRAME_BYTES + 1);
  localparam int TIMER_BITS_DEF   = 16;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_LOST = 2'd2;

  // Configuration register indices
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_PAIR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PAIR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_CMD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_DATA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       echo_window;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_byte3;
    logic [15:0] cmd_word;
    logic [15:0] data_word;
    logic        link_up;
  } out_item_t;

  typedef struct packed {
    logic [15:0] header_pair;
    logic [15:0] tail_pair;
    logic [15:0] heartbeat_cmd;
    logic [15:0] heartbeat_data;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

@@ rtl/fprhb_engine.sv @@
// Frame window, link state and watchdog timer; decides the result of one item.
// Depends on fprhb_pkg and framed_packet_receiver_heartbeat_core_assert.svh.
`include "framed_packet_receiver_heartbeat_core_assert.svh"

module fprhb_engine #(
  parameter int TIMER_BITS = fprhb_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fprhb_pkg::cfg_t      cfg,
  input  logic                 fire,
  input  fprhb_pkg::in_item_t  item,
  output logic                 res_valid,
  output fprhb_pkg::out_item_t res
);

  localparam int FB = fprhb_pkg::FRAME_BYTES;
  localparam int FW = fprhb_pkg::FILL_W;
  localparam logic [FW-1:0] FILL_LAST = FW'(FB - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(FB);
  localparam logic [31:0]   TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  // Window holds the most recent bytes, newest at the top index
  logic [7:0]            win_r [FB];
  logic [7:0]            win_nxt [FB];
  logic [FW-1:0]         fill_r, fill_nxt, fill_inc;
  logic                  connected_r, connected_nxt;
  logic [TIMER_BITS-1:0] ticks_r, ticks_nxt, reload;
  logic [31:0]           tmo_ext;
  logic                  is_byte, is_tick, full, hdr_ok, sum_ok, is_hb;
  logic [15:0]           cmd, dat, chk;

  // Shifted window with the incoming byte
  always_comb begin
    for (int i = 0; i < FB - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[FB - 1] = item.rx_byte;
  end

  assign is_tick  = (item.kind == fprhb_pkg::KIND_TICK);
  assign is_byte  = (item.kind == fprhb_pkg::KIND_BYTE) && !item.echo_window;
  assign fill_inc = fill_r + FW'(1);
  assign full     = (fill_inc == FILL_FULL);

  // Frame checks on the updated window
  assign hdr_ok = (win_nxt[0] == cfg.header_pair[7:0]) &&
                  (win_nxt[1] == cfg.header_pair[15:8]) &&
                  (win_nxt[FB - 2] == cfg.tail_pair[7:0]) &&
                  (win_nxt[FB - 1] == cfg.tail_pair[15:8]);
  assign cmd    = {win_nxt[5], win_nxt[4]};
  assign dat    = {win_nxt[7], win_nxt[6]};
  assign chk    = {win_nxt[9], win_nxt[8]};
  assign sum_ok = (chk == 16'(cmd + dat));
  assign is_hb  = (cmd == cfg.heartbeat_cmd) && (dat == cfg.heartbeat_data);

  // Watchdog reload saturates at the timer range
  assign tmo_ext = 32'(cfg.timeout_ticks);
  assign reload  = (tmo_ext > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                         : tmo_ext[TIMER_BITS-1:0];

  // Next state and result
  always_comb begin
    fill_nxt      = fill_r;
    connected_nxt = connected_r;
    ticks_nxt     = ticks_r;
    res_valid     = 1'b0;
    res.event_res = fprhb_pkg::EV_DATA;
    if (is_tick) begin
      if (connected_r) begin
        if (ticks_r <= TIMER_BITS'(1)) begin
          ticks_nxt     = '0;
          connected_nxt = 1'b0;
          res_valid     = 1'b1;
          res.event_res = fprhb_pkg::EV_LOST;
        end else begin
          ticks_nxt = ticks_r - TIMER_BITS'(1);
        end
      end else if (ticks_r != '0) begin
        ticks_nxt = ticks_r - TIMER_BITS'(1);
      end
    end else if (is_byte) begin
      if (!full) begin
        fill_nxt = fill_inc;
      end else if (!hdr_ok) begin
        // resync: drop the oldest byte
        fill_nxt = FILL_LAST;
      end else begin
        fill_nxt = '0;
        if (sum_ok) begin
          if (is_hb) begin
            ticks_nxt = reload;
            if (!connected_r) begin
              connected_nxt = 1'b1;
              res_valid     = 1'b1;
              res.event_res = fprhb_pkg::EV_UP;
            end
          end else begin
            res_valid     = 1'b1;
            res.event_res = fprhb_pkg::EV_DATA;
          end
        end
      end
    end
    // frame fields are zero on a link-lost event
    res.frame_byte2 = is_tick ? 8'd0 : win_nxt[2];
    res.frame_byte3 = is_tick ? 8'd0 : win_nxt[3];
    res.cmd_word    = is_tick ? 16'd0 : cmd;
    res.data_word   = is_tick ? 16'd0 : dat;
    res.link_up     = connected_nxt;
  end

  // Window shifts on every kept byte
  always_ff @(posedge clk) begin
    if (fire && is_byte) begin
      for (int i = 0; i < FB; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      connected_r <= 1'b0;
      ticks_r     <= '0;
    end else if (fire) begin
      fill_r      <= fill_nxt;
      connected_r <= connected_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  `FPRHB_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_r <= FILL_LAST, "window fill out of range")
  `FPRHB_ASSERT_NEXT(a_lost_clears, fire && res_valid && (res.event_res == fprhb_pkg::EV_LOST), !connected_r && (ticks_r == '0), "link lost without clearing state")
  `FPRHB_ASSERT_NEXT(a_up_reloads, fire && res_valid && (res.event_res == fprhb_pkg::EV_UP), connected_r && (ticks_r == $past(reload)), "link up without reload")
  `FPRHB_ASSERT_IMPLY(a_rise_has_event, $rose(connected_r), $past(fire && res_valid && (res.event_res == fprhb_pkg::EV_UP)), "link rose without an up event")

endmodule

@@ rtl/framed_packet_receiver_heartbeat_core.sv @@
// Top level of the framed packet receiver with heartbeat watchdog.
// Depends on fprhb_pkg and fprhb_engine.
//
// Usage:
//   in_*  : one item per handshake, either a received byte (kind 0) or a time
//           tick (kind 1). A byte with echo_window set is discarded.
//   out_* : result items: data frame delivered, link came up, or link lost.
//   cfg_* : register writes (header, tail, heartbeat words, timeout); cfg_ready
//           is always high. Write only while the block is idle.
// Path: an accepted item waits in the input register until the result slot is
//   free; its result, if any, is registered and shown on out_* from then on.
// Throughput: one item per cycle unless out_stall holds a result; frame checks
//   and checksum add are one combinational pass from input to result register.
// Stall: with a result held under out_stall, the input register still takes
//   one item; in_stall then rises until the result is taken.
// Reset: synchronous, active low; clears the window fill, link flag, timer and
//   both registers' valid flags, and loads the register reset values.

module framed_packet_receiver_heartbeat_core #(
  parameter int TIMER_BITS = fprhb_pkg::TIMER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fprhb_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fprhb_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fprhb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_data
);

  fprhb_pkg::cfg_t      cfg_r;
  fprhb_pkg::in_item_t  in_item_r;
  fprhb_pkg::out_item_t out_item_r, res;
  logic                 in_valid_r, out_valid_r, advance, res_valid;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_pair    <= '0;
      cfg_r.tail_pair      <= '0;
      cfg_r.heartbeat_cmd  <= '0;
      cfg_r.heartbeat_data <= '0;
      cfg_r.timeout_ticks  <= fprhb_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fprhb_pkg::REG_HEADER_PAIR:    cfg_r.header_pair    <= cfg_data;
        fprhb_pkg::REG_TAIL_PAIR:      cfg_r.tail_pair      <= cfg_data;
        fprhb_pkg::REG_HEARTBEAT_CMD:  cfg_r.heartbeat_cmd  <= cfg_data;
        fprhb_pkg::REG_HEARTBEAT_DATA: cfg_r.heartbeat_data <= cfg_data;
        fprhb_pkg::REG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item in the input register moves on when the result slot is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  fprhb_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fire      (advance),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ dv/fprhb_frame_checker.sv @@
// Checker for the framed packet receiver: watches the item, result and register channels,
// predicts every result from its own model of the deframer and watchdog, and compares them.
// Depends on fprhb_pkg.
module fprhb_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fprhb_pkg::in_item_t             in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fprhb_pkg::out_item_t            out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fprhb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              n_data,
  output int                              n_up,
  output int                              n_lost
);
  timeunit 1ns;
  timeprecision 1ps;

  import fprhb_pkg::*;

  // Own copy of the registers and of the receiver state
  cfg_t        regs;
  logic [7:0]  win [FRAME_BYTES];
  int unsigned fill;
  bit          link;
  logic [15:0] ticks_left;

  // Events still owed by the block, oldest first
  out_item_t   owed_events [$];
  int          n_owed;
  int          n_taken;

  assign pending = n_owed - n_taken;

  task automatic owe_event(input out_item_t ev);
    owed_events.push_back(ev);
    n_owed++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Advance the deframer and watchdog by one item; record any event it causes
  task automatic deframe_item(input in_item_t it);
    out_item_t   ev;
    logic [15:0] cmd;
    logic [15:0] dat;
    logic [15:0] sum;
    bit          framed;
    ev = '0;
    if (it.kind == KIND_TICK) begin
      if (link) begin
        if (ticks_left <= 16'd1) begin
          ticks_left = '0;
          link = 1'b0;
          ev.event_res = EV_LOST;
          ev.link_up = 1'b0;
          owe_event(ev);
        end else begin
          ticks_left = ticks_left - 16'd1;
        end
      end else if (ticks_left != '0) begin
        ticks_left = ticks_left - 16'd1;
      end
    end else if (!it.echo_window) begin
      if (fill >= FRAME_BYTES) fill = FRAME_BYTES - 1;
      win[fill] = it.rx_byte;
      fill++;
      if (fill == FRAME_BYTES) begin
        framed = (win[0] == regs.header_pair[7:0]) && (win[1] == regs.header_pair[15:8]) &&
                 (win[10] == regs.tail_pair[7:0]) && (win[11] == regs.tail_pair[15:8]);
        if (framed) begin
          cmd = {win[5], win[4]};
          dat = {win[7], win[6]};
          sum = {win[9], win[8]};
          fill = 0;
          ev.frame_byte2 = win[2];
          ev.frame_byte3 = win[3];
          ev.cmd_word = cmd;
          ev.data_word = dat;
          // 16-bit context, so the sum wraps; a bad checksum drops the frame silently
          if (sum == cmd + dat) begin
            if (cmd == regs.heartbeat_cmd && dat == regs.heartbeat_data) begin
              // timer is as wide as the register, so the reload needs no clamp
              ticks_left = regs.timeout_ticks;
              if (!link) begin
                link = 1'b1;
                ev.event_res = EV_UP;
                ev.link_up = 1'b1;
                owe_event(ev);
              end
            end else begin
              ev.event_res = EV_DATA;
              ev.link_up = link;
              owe_event(ev);
            end
          end
        end else begin
          // no frame here: drop the oldest byte and try again on the next one
          for (int i = 0; i < FRAME_BYTES - 1; i++) win[i] = win[i + 1];
          win[FRAME_BYTES - 1] = '0;
          fill = FRAME_BYTES - 1;
        end
      end
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin : watch
    out_item_t want_ev;
    if (!rst_n) begin
      regs = '0;
      regs.timeout_ticks = TIMEOUT_RESET;
      for (int i = 0; i < FRAME_BYTES; i++) win[i] = '0;
      fill = 0;
      link = 1'b0;
      ticks_left = '0;
      owed_events.delete();
      n_owed = 0;
      n_taken = 0;
      errors = 0;
      n_data = 0;
      n_up = 0;
      n_lost = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER_PAIR:    regs.header_pair = cfg_data;
          REG_TAIL_PAIR:      regs.tail_pair = cfg_data;
          REG_HEARTBEAT_CMD:  regs.heartbeat_cmd = cfg_data;
          REG_HEARTBEAT_DATA: regs.heartbeat_data = cfg_data;
          REG_TIMEOUT_TICKS:  regs.timeout_ticks = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_events.size() == 0) begin
          $error("result with nothing owed: event_res %0d, cmd_word %0h",
                 out_item.event_res, out_item.cmd_word);
          errors++;
        end else begin
          want_ev = owed_events.pop_front();
          n_taken++;
          check_field("event_res", 16'(want_ev.event_res), 16'(out_item.event_res));
          check_field("frame_byte2", 16'(want_ev.frame_byte2), 16'(out_item.frame_byte2));
          check_field("frame_byte3", 16'(want_ev.frame_byte3), 16'(out_item.frame_byte3));
          check_field("cmd_word", want_ev.cmd_word, out_item.cmd_word);
          check_field("data_word", want_ev.data_word, out_item.data_word);
          check_field("link_up", 16'(want_ev.link_up), 16'(out_item.link_up));
          case (want_ev.event_res)
            EV_DATA: n_data++;
            EV_UP:   n_up++;
            default: n_lost++;
          endcase
        end
      end
      if (in_valid && !in_stall) deframe_item(in_item);
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the framed packet receiver testbench: clock, reset, register settings and item
// stimulus (framed traffic, heartbeats, ticks, echo and noise), with random gaps and stalls.
// Depends on fprhb_pkg, framed_packet_receiver_heartbeat_core and fprhb_frame_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fprhb_pkg::*;

  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 195;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_TIMEOUT_TICKS + 1);

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int errors;
  int pending;
  int n_data;
  int n_up;
  int n_lost;

  // Stimulus-side view of the registers, used to build frames
  cfg_t cur;
  int   phase_items;
  int   total_items;
  int   n_settings;
  bit   no_gaps;
  bit   noisy;

  framed_packet_receiver_heartbeat_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fprhb_frame_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .n_data    (n_data),
    .n_up      (n_up),
    .n_lost    (n_lost)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Idle length before an item: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure, with long free-running stretches now and then
  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      n = ($urandom_range(0, 99) < 15) ? $urandom_range(80, 200) : pick_gap();
      @(negedge clk) out_stall <= 1'b0;
      repeat (n) @(negedge clk);
      n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clk) out_stall <= 1'b1;
      repeat (n - 1) @(negedge clk);
    end
  end

  // Offer one item and hold it until taken
  task automatic push_item(input in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (it.kind == KIND_TICK || !it.echo_window) begin
      phase_items++;
      total_items++;
    end
  endtask

  task automatic send_tick();
    in_item_t it;
    it.kind = KIND_TICK;
    it.rx_byte = 8'($urandom);
    it.echo_window = 1'($urandom_range(0, 1));
    push_item(it);
  endtask

  task automatic send_echo(input logic [7:0] b);
    in_item_t it;
    it.kind = KIND_BYTE;
    it.rx_byte = b;
    it.echo_window = 1'b1;
    push_item(it);
  endtask

  // A received byte, with echo bytes and ticks now and then slipped in before it
  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    if (noisy && $urandom_range(0, 99) < 5) send_echo(8'($urandom));
    if (noisy && $urandom_range(0, 99) < 4) send_tick();
    it.kind = KIND_BYTE;
    it.rx_byte = b;
    it.echo_window = 1'b0;
    push_item(it);
  endtask

  // First len bytes of a frame; words go low byte first
  task automatic send_frame(input logic [15:0] hdr, input logic [15:0] b23,
                            input logic [15:0] cmd, input logic [15:0] dat,
                            input logic [15:0] sum, input logic [15:0] tl, input int len);
    logic [7:0] bytes [FRAME_BYTES];
    bytes = '{hdr[7:0], hdr[15:8], b23[7:0], b23[15:8], cmd[7:0], cmd[15:8],
              dat[7:0], dat[15:8], sum[7:0], sum[15:8], tl[7:0], tl[15:8]};
    for (int i = 0; i < len; i++) send_byte(bytes[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Let every owed result drain, then let items still in flight settle
  task automatic quiesce(input int settle);
    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (settle) @(posedge clk);
  endtask

  // Register setting per phase: the first three hold the extremes
  task automatic apply_setting(input int p);
    cur.header_pair = 16'($urandom);
    cur.tail_pair = 16'($urandom);
    cur.heartbeat_cmd = 16'($urandom);
    cur.heartbeat_data = 16'($urandom);
    cur.timeout_ticks = 16'($urandom_range(2, 40));
    case (p)
      0: cur = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd1};
      1: cur = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd0};
      2: cur.timeout_ticks = 16'hFFFF;
      default: ;
    endcase
    write_reg(REG_HEADER_PAIR, cur.header_pair);
    write_reg(REG_TAIL_PAIR, cur.tail_pair);
    write_reg(REG_HEARTBEAT_CMD, cur.heartbeat_cmd);
    write_reg(REG_HEARTBEAT_DATA, cur.heartbeat_data);
    write_reg(REG_TIMEOUT_TICKS, cur.timeout_ticks);
    // out-of-range index: must leave every register alone
    write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    @(negedge clk) cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed frames with random content, the rest broken frames, ticks and noise
  task automatic run_phase(input int quota);
    int          r;
    logic [15:0] cmd;
    logic [15:0] dat;
    logic [15:0] b23;
    phase_items = 0;
    while (phase_items < quota) begin
      r = $urandom_range(0, 99);
      cmd = 16'($urandom);
      dat = 16'($urandom);
      b23 = 16'($urandom);
      if ($urandom_range(0, 15) == 0) cmd = '1;
      if ($urandom_range(0, 15) == 0) dat = '0;
      if (r < 42) begin
        send_frame(cur.header_pair, b23, cmd, dat, cmd + dat, cur.tail_pair, FRAME_BYTES);
      end else if (r < 57) begin
        send_frame(cur.header_pair, b23, cur.heartbeat_cmd, cur.heartbeat_data,
                   cur.heartbeat_cmd + cur.heartbeat_data, cur.tail_pair, FRAME_BYTES);
      end else if (r < 64) begin
        send_frame(cur.header_pair, b23, cmd, dat, cmd + dat + 16'($urandom_range(1, 65535)),
                   cur.tail_pair, FRAME_BYTES);
      end else if (r < 68) begin
        send_frame(cur.header_pair, b23, cmd, dat, cmd + dat,
                   cur.tail_pair ^ 16'($urandom_range(1, 65535)), FRAME_BYTES);
      end else if (r < 71) begin
        send_frame(cur.header_pair ^ 16'($urandom_range(1, 65535)), b23, cmd, dat, cmd + dat,
                   cur.tail_pair, FRAME_BYTES);
      end else if (r < 75) begin
        send_frame(cur.header_pair, b23, cmd, dat, cmd + dat, cur.tail_pair,
                   $urandom_range(1, FRAME_BYTES - 1));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 10)) send_tick();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur = '0;
    cur.timeout_ticks = TIMEOUT_RESET;
    total_items = 0;
    n_settings = 0;
    no_gaps = 1'b0;
    noisy = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed, on reset registers: all-zero heartbeat brings the link up, then a tick,
    // an echo byte of all ones, and a data frame with all-ones command and bytes 2 and 3 and a wrapping sum
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, FRAME_BYTES);
    send_tick();
    send_echo(8'hFF);
    send_frame(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, FRAME_BYTES);

    // Random phases, each under its own register setting
    noisy = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce(4);
      apply_setting(p);
      no_gaps = (p % 4 == 3);
      run_phase(PHASE_ITEMS);
    end

    quiesce(8);
    $display("Run covered %0d items under %0d register settings plus reset values.",
             total_items, n_settings);
    $display("Results checked: %0d data frames, %0d link up, %0d link lost.",
             n_data, n_up, n_lost);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fprhb_pkg.sv
rtl/fprhb_engine.sv
rtl/framed_packet_receiver_heartbeat_core.sv
dv/fprhb_frame_checker.sv
dv/testbench.sv
